>>> design/irc_lft_pkg.sv
// Shared types, constants and line tokenizer functions for the IRC line framer.
package irc_lft_pkg;

  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_COLON = 8'd58;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_VT    = 8'd11;
  localparam logic [7:0] BYTE_FF    = 8'd12;

  localparam int unsigned LEN_W          = 10;
  localparam int unsigned CNT_W          = 4;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd510;
  localparam int unsigned MAX_PARAMS_DEF = 15;
  localparam int unsigned RES_DEPTH      = 4;

  typedef enum logic [1:0] {
    KIND_PREFIX = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_MIDDLE = 2'd2,
    KIND_TRAIL  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [LEN_W-1:0] line_length;
    logic             discarding;
    logic             cr_pending;
    logic             prev_was_space;
    logic             bad_seen;
    kind_e            kind;
    logic [CNT_W-1:0] param_counter;
    logic             token_begins;
  } line_st_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [1:0]       token_kind;
    logic [CNT_W-1:0] param_index;
    logic             token_first;
    logic             line_end;
    logic             line_bad;
    logic             line_truncated;
    logic [CNT_W-1:0] param_total;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    line_st_t st;
    logic     emit;
    res_t     res;
  } content_ret_t;

  // Up to two results produced by one accepted item, in delivery order.
  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  function automatic line_st_t line_clear(line_st_t st);
    line_st_t r;
    r = st;
    r.line_length    = '0;
    r.prev_was_space = 1'b0;
    r.bad_seen       = 1'b0;
    r.kind           = KIND_PREFIX;
    r.param_counter  = '0;
    r.token_begins   = 1'b1;
    return r;
  endfunction

  function automatic res_t end_res(logic bad, logic trunc, logic [CNT_W-1:0] total);
    res_t r;
    r = '0;
    r.line_end       = 1'b1;
    r.line_bad       = bad;
    r.line_truncated = trunc;
    r.param_total    = total;
    return r;
  endfunction

  function automatic res_t byte_res(logic [7:0] c, kind_e kind, logic [CNT_W-1:0] idx,
                                    logic first);
    res_t r;
    r = '0;
    r.out_byte    = c;
    r.token_kind  = kind;
    r.param_index = idx;
    r.token_first = first;
    return r;
  endfunction

  // Handle one content byte: overflow check, bad-line flags and token tagging.
  function automatic content_ret_t content_step(line_st_t st, logic [7:0] c,
                                                logic [LEN_W-1:0] max_len,
                                                logic [CNT_W-1:0] limit);
    content_ret_t r;
    logic         first_byte;
    r          = '0;
    r.st       = st;
    first_byte = (st.line_length == '0);
    if (st.line_length >= max_len) begin
      r.emit          = 1'b1;
      r.res           = end_res(st.bad_seen, 1'b1, st.param_counter);
      r.st            = line_clear(st);
      r.st.discarding = 1'b1;
      r.st.cr_pending = 1'b0;
    end else begin
      r.st.line_length = st.line_length + 1'b1;
      if (c == BYTE_TAB || c == BYTE_VT || c == BYTE_FF) begin
        r.st.bad_seen = 1'b1;
      end
      if (c == BYTE_SPACE && st.prev_was_space) begin
        r.st.bad_seen = 1'b1;
      end
      r.st.prev_was_space = (c == BYTE_SPACE);
      if (first_byte) begin
        r.st.token_begins = 1'b1;
        r.st.kind         = (c == BYTE_COLON) ? KIND_PREFIX : KIND_CMD;
      end
      if (first_byte && c == BYTE_COLON) begin
        r.emit            = 1'b1;
        r.res             = byte_res(c, KIND_PREFIX, '0, 1'b1);
        r.st.token_begins = 1'b0;
      end else if (r.st.kind == KIND_TRAIL) begin
        r.emit            = 1'b1;
        r.res             = byte_res(c, KIND_TRAIL, '0, r.st.token_begins);
        r.st.token_begins = 1'b0;
      end else if (c == BYTE_SPACE) begin
        // Separator: advance the token kind or count an empty parameter
        if (r.st.kind == KIND_PREFIX) begin
          r.st.kind = KIND_CMD;
        end else if (r.st.kind == KIND_CMD) begin
          r.st.kind = KIND_MIDDLE;
        end else if (r.st.token_begins && r.st.param_counter < limit) begin
          r.st.param_counter = r.st.param_counter + 1'b1;
        end
        r.st.token_begins = 1'b1;
      end else if (r.st.kind == KIND_MIDDLE && r.st.token_begins && c == BYTE_COLON) begin
        r.st.kind         = KIND_TRAIL;
        r.st.token_begins = 1'b1;
      end else begin
        if (r.st.kind == KIND_MIDDLE && r.st.token_begins &&
            r.st.param_counter < limit) begin
          r.st.param_counter = r.st.param_counter + 1'b1;
        end
        r.emit = 1'b1;
        r.res  = byte_res(c, r.st.kind,
                          (r.st.kind == KIND_MIDDLE) ? r.st.param_counter - 1'b1 : '0,
                          r.st.token_begins);
        r.st.token_begins = 1'b0;
      end
    end
    return r;
  endfunction

  // Drop bytes until CR LF, tracking a CR split across items.
  function automatic line_st_t discard_step(line_st_t st, logic [7:0] b);
    line_st_t r;
    r = st;
    if (st.cr_pending && b == BYTE_LF) begin
      r.discarding = 1'b0;
      r.cr_pending = 1'b0;
    end else begin
      r.cr_pending = (b == BYTE_CR);
    end
    return r;
  endfunction

endpackage

>>> design/irc_lft_if.sv
// Valid/ready channel interfaces for received bytes, token results and configuration.
interface irc_lft_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface irc_lft_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] token_kind;
  logic [3:0] param_index;
  logic       token_first;
  logic       line_end;
  logic       line_bad;
  logic       line_truncated;
  logic [3:0] param_total;
  logic       last_of_run;
  modport source (output valid, output out_byte, output token_kind, output param_index,
                  output token_first, output line_end, output line_bad,
                  output line_truncated, output param_total, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input token_kind, input param_index,
                input token_first, input line_end, input line_bad,
                input line_truncated, input param_total, input last_of_run,
                output ready);
endinterface

interface irc_lft_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] max_line_len;
  modport source (output valid, output max_line_len, input ready);
  modport sink (input valid, input max_line_len, output ready);
endinterface

>>> design/irc_lft_core.sv
// Line framer state and per-item tokenizer step producing up to two results.
module irc_lft_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [irc_lft_pkg::CNT_W-1:0]  param_limit_i,
  input  logic                           accept_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           cfg_we_i,
  input  logic [irc_lft_pkg::LEN_W-1:0]  cfg_max_len_i,
  output irc_lft_pkg::push_t             push_o
);

  irc_lft_pkg::line_st_t     st_q, st_d, st_mid;
  logic [irc_lft_pkg::LEN_W-1:0] max_len_q;
  irc_lft_pkg::content_ret_t r1, r2;
  irc_lft_pkg::push_t        push;

  // Compute the step for the presented byte
  always_comb begin
    st_mid = st_q;
    r1     = '0;
    r2     = '0;
    st_d   = st_q;
    if (st_q.discarding) begin
      st_d = irc_lft_pkg::discard_step(st_q, rx_byte_i);
    end else if (st_q.cr_pending && rx_byte_i == irc_lft_pkg::BYTE_LF) begin
      // CR LF closes the line
      r1.emit = 1'b1;
      r1.res  = irc_lft_pkg::end_res(st_q.bad_seen, 1'b0, st_q.param_counter);
      st_d    = irc_lft_pkg::line_clear(st_q);
      st_d.cr_pending = 1'b0;
    end else begin
      // Release a held CR as content first
      if (st_q.cr_pending) begin
        st_mid.cr_pending = 1'b0;
        r1     = irc_lft_pkg::content_step(st_mid, irc_lft_pkg::BYTE_CR, max_len_q,
                                           param_limit_i);
        st_mid = r1.st;
      end
      if (st_mid.discarding) begin
        st_d = irc_lft_pkg::discard_step(st_mid, rx_byte_i);
      end else if (rx_byte_i == irc_lft_pkg::BYTE_CR) begin
        st_d = st_mid;
        st_d.cr_pending = 1'b1;
      end else begin
        r2   = irc_lft_pkg::content_step(st_mid, rx_byte_i, max_len_q, param_limit_i);
        st_d = r2.st;
      end
    end
  end

  // Pack results in order and mark the last one of the run
  always_comb begin
    push = '0;
    if (accept_i) begin
      if (r1.emit) begin
        push.a = r1.res;
        push.b = r2.res;
        push.n = r2.emit ? 2'd2 : 2'd1;
        if (r2.emit) begin
          push.b.last_of_run = 1'b1;
        end else begin
          push.a.last_of_run = 1'b1;
        end
      end else if (r2.emit) begin
        push.a = r2.res;
        push.a.last_of_run = 1'b1;
        push.n = 2'd1;
      end
    end
  end

  assign push_o = push;

  // Advance line state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= irc_lft_pkg::line_clear('0);
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

  // Hold the configured line limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= irc_lft_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_max_len_i;
    end
  end

  // Check result packing for each step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (push.b.last_of_run && !push.a.last_of_run))
    else $error("two-result run marks wrong last result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && st_q.discarding) |-> (push.n == 2'd0))
    else $error("result emitted while discarding");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0 && push.a.line_end) |-> (push.a.out_byte == 8'd0))
    else $error("line end result carries a byte");

endmodule

>>> design/irc_lft_resq.sv
// Result queue: registers pushed results and delivers one item per cycle while the consumer is ready.
module irc_lft_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  irc_lft_pkg::push_t push_i,
  output logic               space_o,
  irc_lft_tok_if.source      tok
);

  localparam int unsigned PtrW = $clog2(irc_lft_pkg::RES_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  irc_lft_pkg::res_t mem_q [irc_lft_pkg::RES_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              pop;
  irc_lft_pkg::res_t head;

  assign pop     = tok.valid && tok.ready;
  assign space_o = (count_q <= CntW'(irc_lft_pkg::RES_DEPTH - 2));
  assign head    = mem_q[rd_ptr_q];

  // Drive the output channel from the queue head
  assign tok.valid          = (count_q != '0);
  assign tok.out_byte       = head.out_byte;
  assign tok.token_kind     = head.token_kind;
  assign tok.param_index    = head.param_index;
  assign tok.token_first    = head.token_first;
  assign tok.line_end       = head.line_end;
  assign tok.line_bad       = head.line_bad;
  assign tok.line_truncated = head.line_truncated;
  assign tok.param_total    = head.param_total;
  assign tok.last_of_run    = head.last_of_run;

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.a;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_q + 1'b1] <= push_i.b;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_i.n) - CntW'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(irc_lft_pkg::RES_DEPTH))
    else $error("result queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (count_q <= CntW'(irc_lft_pkg::RES_DEPTH - 2)))
    else $error("push without room for two results");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && push_i.n == 2'd0) |=> !tok.valid)
    else $error("output valid with empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd3)
    else $error("more than two results from one item");

endmodule

>>> design/irc_line_framer_tokenizer.sv
// Top level: IRC line framer and tokenizer with byte input and token result channels.
// Results are registered in the result queue before they are offered on tok_o.
// Throughput: one byte per cycle while ready is high; a byte that releases a held CR
// gives two results and the four-entry result queue delivers them one per cycle while
// tok_o is ready. Ready drops while fewer than two queue entries are free.
// Reset: line state cleared, max_line_len returns to 510, result queue empty.
module irc_line_framer_tokenizer #(
  parameter int unsigned MaxParams = irc_lft_pkg::MAX_PARAMS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  irc_lft_rx_if.sink    rx_i,
  irc_lft_tok_if.source tok_o,
  irc_lft_cfg_if.sink   cfg_i
);

  localparam int unsigned ParamLimit = (MaxParams < 15) ? MaxParams : 15;

  irc_lft_pkg::push_t push;
  logic               space;
  logic               accept;

  // Take a byte whenever the queue can absorb two results
  assign rx_i.ready  = space;
  assign accept      = rx_i.valid && space;
  assign cfg_i.ready = 1'b1;

  irc_lft_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .param_limit_i (irc_lft_pkg::CNT_W'(ParamLimit)),
    .accept_i      (accept),
    .rx_byte_i     (rx_i.rx_byte),
    .cfg_we_i      (cfg_i.valid),
    .cfg_max_len_i (cfg_i.max_line_len),
    .push_o        (push)
  );

  irc_lft_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .tok     (tok_o)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the IRC line framer and tokenizer: random bytes in, tokens checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import irc_lft_pkg::*;

  localparam int unsigned PARAM_CAP     = (MAX_PARAMS_DEF < 15) ? MAX_PARAMS_DEF : 15;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned PHASE_BYTES   = 58;

  typedef enum logic [1:0] {
    STIM_BYTE,
    STIM_CONFIG,
    STIM_SETTLE
  } stim_op_e;

  typedef enum logic [1:0] {
    FLOW_OPEN,
    FLOW_LIGHT,
    FLOW_HEAVY,
    FLOW_BEAT
  } flow_mode_e;

  typedef struct {
    stim_op_e   op;
    logic [9:0] value;
  } stim_t;

  logic clk_i;
  logic rst_ni;

  irc_lft_rx_if  rx_ch ();
  irc_lft_tok_if tok_ch ();
  irc_lft_cfg_if cfg_ch ();

  irc_line_framer_tokenizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .tok_o  (tok_ch),
    .cfg_i  (cfg_ch)
  );

  // Stimulus feed and the tokens the framer owes us
  stim_t byte_feed[$];
  res_t  tokens_due[$];
  res_t  step_tokens[$];

  // Shadow of the framer's line state and its length register
  logic [9:0] len_limit      = MAX_LEN_RESET;
  logic [9:0] line_len       = '0;
  bit         dropping       = 1'b0;
  bit         cr_held        = 1'b0;
  bit         last_space     = 1'b0;
  bit         line_flawed    = 1'b0;
  kind_e      kind_now       = KIND_PREFIX;
  logic [3:0] mid_count      = '0;
  bit         at_token_start = 1'b1;

  int unsigned mismatches    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned bytes_taken   = 0;
  int unsigned tokens_seen   = 0;
  int unsigned lines_framed  = 0;
  int unsigned lines_cut     = 0;
  int unsigned lines_flawed  = 0;
  int unsigned limit_writes  = 0;
  int unsigned beat_count    = 0;

  logic [7:0] opening_seq[$] = '{
    BYTE_CR, BYTE_LF,
    BYTE_COLON, 8'hFF, BYTE_SPACE, "A", 8'h00, BYTE_SPACE, "b", BYTE_SPACE, BYTE_SPACE,
    BYTE_COLON, "c", BYTE_SPACE, "d", BYTE_CR, BYTE_LF,
    "Q", BYTE_CR, "R", BYTE_CR, BYTE_CR, BYTE_TAB, BYTE_VT, BYTE_FF, BYTE_CR, BYTE_LF
  };

  // ---------------------------------------------------------------------------
  // Line framing and token tagging
  // ---------------------------------------------------------------------------

  function automatic void restart_line();
    line_len       = '0;
    last_space     = 1'b0;
    line_flawed    = 1'b0;
    kind_now       = KIND_PREFIX;
    mid_count      = '0;
    at_token_start = 1'b1;
  endfunction

  function automatic void add_token(logic [7:0] b, kind_e k, logic [3:0] idx, bit first);
    res_t r;
    r             = '0;
    r.out_byte    = b;
    r.token_kind  = k;
    r.param_index = idx;
    r.token_first = first;
    step_tokens.insert(step_tokens.size(), r);
  endfunction

  function automatic void close_line(bit cut);
    res_t r;
    r                = '0;
    r.line_end       = 1'b1;
    r.line_bad       = line_flawed;
    r.line_truncated = cut;
    r.param_total    = mid_count;
    step_tokens.insert(step_tokens.size(), r);
    lines_framed++;
    if (cut) lines_cut++;
    if (line_flawed) lines_flawed++;
    restart_line();
  endfunction

  function automatic void bump_params();
    if (mid_count < PARAM_CAP) mid_count++;
  endfunction

  // Tag one content byte, or close the line as cut when it is full
  function automatic void take_content(logic [7:0] c);
    bit         first;
    logic [3:0] idx;
    if (line_len >= len_limit) begin
      close_line(1'b1);
      dropping = 1'b1;
      cr_held  = 1'b0;
      return;
    end
    first = (line_len == '0);
    line_len++;
    if (c == BYTE_TAB || c == BYTE_VT || c == BYTE_FF) line_flawed = 1'b1;
    if (c == BYTE_SPACE && last_space) line_flawed = 1'b1;
    last_space = (c == BYTE_SPACE);

    if (first) begin
      at_token_start = 1'b1;
      if (c == BYTE_COLON) begin
        kind_now = KIND_PREFIX;
        add_token(c, KIND_PREFIX, '0, 1'b1);
        at_token_start = 1'b0;
        return;
      end
      kind_now = KIND_CMD;
    end
    if (kind_now == KIND_TRAIL) begin
      add_token(c, KIND_TRAIL, '0, at_token_start);
      at_token_start = 1'b0;
      return;
    end
    // Separator: move on to the next token kind or count an empty parameter
    if (c == BYTE_SPACE) begin
      if (kind_now == KIND_PREFIX) begin
        kind_now = KIND_CMD;
      end else if (kind_now == KIND_CMD) begin
        kind_now = KIND_MIDDLE;
      end else if (at_token_start) begin
        bump_params();
      end
      at_token_start = 1'b1;
      return;
    end
    if (kind_now == KIND_MIDDLE && at_token_start && c == BYTE_COLON) begin
      kind_now       = KIND_TRAIL;
      at_token_start = 1'b1;
      return;
    end
    idx = '0;
    if (kind_now == KIND_MIDDLE) begin
      if (at_token_start) bump_params();
      idx = mid_count - 4'd1;
    end
    add_token(c, kind_now, idx, at_token_start);
    at_token_start = 1'b0;
  endfunction

  // Skip bytes until CR LF, also when the pair straddles two items
  function automatic void drop_byte(logic [7:0] b);
    if (cr_held && b == BYTE_LF) begin
      dropping = 1'b0;
      cr_held  = 1'b0;
    end else begin
      cr_held = (b == BYTE_CR);
    end
  endfunction

  function automatic void frame_byte(logic [7:0] b);
    step_tokens.delete();
    if (dropping) begin
      drop_byte(b);
    end else if (cr_held && b == BYTE_LF) begin
      cr_held = 1'b0;
      close_line(1'b0);
    end else begin
      // A held CR that is not followed by LF is plain content
      if (cr_held) begin
        cr_held = 1'b0;
        take_content(BYTE_CR);
      end
      if (dropping) drop_byte(b);
      else if (b == BYTE_CR) cr_held = 1'b1;
      else take_content(b);
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
    foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, driver and monitor
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send bytes in bursts, hold for limit writes and settle pauses
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    stim_t      head;
    bit         drive_rx;
    bit         drive_cfg;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned settle_cnt;
    if (!rst_ni) begin
      rx_ch.valid         <= 1'b0;
      rx_ch.rx_byte       <= '0;
      cfg_ch.valid        <= 1'b0;
      cfg_ch.max_line_len <= '0;
      burst_left = 0;
      gap_left   = 0;
      settle_cnt = 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        bytes_sent++;
        if (!dropping) bytes_taken++;
        frame_byte(rx_ch.rx_byte);
        void'(byte_feed.pop_front());
        if (burst_left != 0) burst_left--;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        len_limit = cfg_ch.max_line_len;
        limit_writes++;
        void'(byte_feed.pop_front());
      end

      drive_rx  = 1'b0;
      drive_cfg = 1'b0;
      if (byte_feed.size() != 0) begin
        head = byte_feed[0];
        case (head.op)
          STIM_SETTLE: begin
            if (tokens_due.size() == 0) begin
              settle_cnt++;
              if (settle_cnt >= SETTLE_CYCLES) begin
                void'(byte_feed.pop_front());
                settle_cnt = 0;
              end
            end else begin
              settle_cnt = 0;
            end
          end
          STIM_CONFIG: begin
            drive_cfg = 1'b1;
          end
          default: begin
            if (burst_left == 0) begin
              gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
              burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 24);
            end
            if (gap_left != 0) gap_left--;
            else drive_rx = 1'b1;
          end
        endcase
      end

      rx_ch.valid  <= drive_rx;
      cfg_ch.valid <= drive_cfg;
      if (drive_rx) rx_ch.rx_byte <= head.value[7:0];
      if (drive_cfg) cfg_ch.max_line_len <= head.value;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Check each delivered token and stall the result channel by mode
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    res_t        want;
    flow_mode_e  flow_mode;
    int unsigned mode_left;
    bit          take;
    if (!rst_ni) begin
      tok_ch.ready <= 1'b0;
      flow_mode = FLOW_OPEN;
      mode_left = 0;
    end else begin
      if (tok_ch.valid && tok_ch.ready) begin
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          $error("unexpected token: out_byte %0d line_end %0d", tok_ch.out_byte,
                 tok_ch.line_end);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          check_field("out_byte", want.out_byte, tok_ch.out_byte);
          check_field("token_kind", want.token_kind, tok_ch.token_kind);
          check_field("param_index", want.param_index, tok_ch.param_index);
          check_field("token_first", want.token_first, tok_ch.token_first);
          check_field("line_end", want.line_end, tok_ch.line_end);
          check_field("line_bad", want.line_bad, tok_ch.line_bad);
          check_field("line_truncated", want.line_truncated, tok_ch.line_truncated);
          check_field("param_total", want.param_total, tok_ch.param_total);
          check_field("last_of_run", want.last_of_run, tok_ch.last_of_run);
        end
      end

      if (mode_left == 0) begin
        flow_mode = flow_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      beat_count++;
      case (flow_mode)
        FLOW_OPEN:  take = 1'b1;
        FLOW_LIGHT: take = ($urandom_range(0, 3) != 0);
        FLOW_HEAVY: take = ($urandom_range(0, 3) == 0);
        default:    take = ((beat_count % 7) < 3);
      endcase
      tok_ch.ready <= take;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(logic [7:0] b);
    stim_t s;
    s.op    = STIM_BYTE;
    s.value = {2'b00, b};
    byte_feed.insert(byte_feed.size(), s);
  endfunction

  function automatic void queue_pause();
    stim_t s;
    s.op    = STIM_SETTLE;
    s.value = '0;
    byte_feed.insert(byte_feed.size(), s);
  endfunction

  function automatic void queue_limit(logic [9:0] v);
    stim_t s;
    queue_pause();
    s.op    = STIM_CONFIG;
    s.value = v;
    byte_feed.insert(byte_feed.size(), s);
  endfunction

  function automatic logic [7:0] word_char();
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] trail_char();
    case ($urandom_range(0, 5))
      0:       return BYTE_SPACE;
      1:       return BYTE_COLON;
      default: return word_char();
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return BYTE_CR;
      1: return BYTE_LF;
      2: return BYTE_SPACE;
      3: return BYTE_COLON;
      4: begin
        case ($urandom_range(0, 2))
          0:       return BYTE_TAB;
          1:       return BYTE_VT;
          default: return BYTE_FF;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed messages with random content, the rest raw noise
  function automatic void queue_random_line();
    int unsigned n_mid;
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 2) == 0) begin
        queue_byte(BYTE_COLON);
        repeat ($urandom_range(1, 5)) queue_byte(word_char());
        queue_byte(BYTE_SPACE);
      end
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(65, 90)));
      n_mid = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 19) : $urandom_range(0, 4);
      repeat (n_mid) begin
        queue_byte(BYTE_SPACE);
        if ($urandom_range(0, 9) != 0) repeat ($urandom_range(1, 3)) queue_byte(word_char());
      end
      if ($urandom_range(0, 2) == 0) begin
        queue_byte(BYTE_SPACE);
        queue_byte(BYTE_COLON);
        repeat ($urandom_range(0, 8)) queue_byte(trail_char());
      end
      if ($urandom_range(0, 15) == 0) queue_byte(BYTE_CR);
      queue_byte(BYTE_CR);
      queue_byte(BYTE_LF);
    end else begin
      repeat ($urandom_range(1, 14)) queue_byte(noise_char());
      if ($urandom_range(0, 1) == 0) begin
        queue_byte(BYTE_CR);
        queue_byte(BYTE_LF);
      end
    end
    if ($urandom_range(0, 11) == 0) queue_pause();
  endfunction

  task automatic run_phase(int unsigned quota);
    int unsigned target;
    target = bytes_sent + quota;
    while (bytes_sent < target) begin
      if (byte_feed.size() < 32) queue_random_line();
      else @(posedge clk_i);
    end
  endtask

  logic [9:0] limit_plan[$] = '{10'd1023, 10'd0, 10'd1, 10'd1022, 10'd3, 10'd9, 10'd24,
                                10'd510};

  initial begin : main_proc
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset limit, then a full drain
    foreach (opening_seq[i]) queue_byte(opening_seq[i]);
    queue_pause();
    run_phase(PHASE_BYTES);

    // Sweep the length limit, extremes included, plus one random setting
    limit_plan.insert(6, 10'($urandom_range(2, 40)));
    foreach (limit_plan[i]) begin
      queue_limit(limit_plan[i]);
      run_phase((limit_plan[i] == 0) ? 12 : PHASE_BYTES);
    end

    while (byte_feed.size() != 0 || tokens_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes (%0d outside dropped spans) over %0d limit writes, %0d tokens.",
             bytes_sent, bytes_taken, limit_writes, tokens_seen);
    $display("Closed %0d lines: %0d cut at the limit, %0d flagged bad.",
             lines_framed, lines_cut, lines_flawed);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop in case the framer hangs
  initial begin : watchdog_proc
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
